@@ rtl/orewma_pkg.sv @@
// ---------------------------------------------------------------------------
// orewma_pkg
// Shared types, constants and controller encodings for the occupancy rate
// tracker.
// ---------------------------------------------------------------------------
package orewma_pkg;

	localparam int DATA_W      = 64;
	localparam int AVG_W       = 48;
	localparam int FRAC_BITS   = 16;
	localparam int THRESH_W    = 16;
	localparam int WLOG_W      = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int TIME_DIV_W  = 6;
	localparam int DIV33_BITS  = 8;
	localparam int DIV33_STEPS = DATA_W / DIV33_BITS;
	localparam int DIV33_CNT_W = $clog2(DIV33_STEPS);
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [DATA_W-1:0]     TIME_MUL = DATA_W'(10);
	localparam logic [TIME_DIV_W:0]   TIME_DIV = (TIME_DIV_W + 1)'(33);

	localparam logic [DATA_W-1:0] CAP48 = {{(DATA_W - AVG_W){1'b0}}, {AVG_W{1'b1}}};
	localparam logic [DATA_W-1:0] LIM   = {DATA_W{1'b1}} >> FRAC_BITS;
	localparam logic [DATA_W-1:0] X_CAP = (LIM < CAP48) ? LIM : CAP48;

	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_WEIGHT = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_WEIGHT  = CFG_INDEX_W'(2);

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10);
	localparam logic [WLOG_W-1:0]   SHORT_RESET  = WLOG_W'(3);
	localparam logic [WLOG_W-1:0]   LONG_RESET   = WLOG_W'(8);

	typedef struct packed {
		logic [DATA_W-1:0] tick_sample;
		logic [DATA_W-1:0] occupancy_total;
	} sample_t;

	typedef struct packed {
		logic [DATA_W-1:0] elapsed_ns;
		logic [DATA_W-1:0] mean_occupancy;
		logic [AVG_W-1:0]  short_average;
		logic [AVG_W-1:0]  long_average;
		logic              averages_updated;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIV33,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_THRESH,
		ST_EWMA_DIFF,
		ST_EWMA_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic scale;
		logic div33_step;
		logic div_start;
		logic mean_load;
		logic x_load;
		logic ewma_diff;
		logic ewma_apply;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic half_zero;
		logic above_thresh;
		logic div_done;
	} status_t;

endpackage

@@ rtl/orewma_div.sv @@
// ---------------------------------------------------------------------------
// orewma_div
// Serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module orewma_div
	import orewma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

@@ rtl/orewma_dp.sv @@
// ---------------------------------------------------------------------------
// orewma_dp
// Datapath: sample history, time scaling, divides, averages and result
// register.
// ---------------------------------------------------------------------------
module orewma_dp
	import orewma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  sample_t                sample,
	output result_t                result,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [THRESH_W-1:0] thresh_q;
	logic [WLOG_W-1:0]   short_wlog_q;
	logic [WLOG_W-1:0]   long_wlog_q;

	logic [DATA_W-1:0] last_ticks_q;
	logic [DATA_W-1:0] last_occ_q;
	logic [DATA_W-1:0] short_acc_q;
	logic [DATA_W-1:0] long_acc_q;

	logic [DATA_W-1:0]     tdelta_q;
	logic [DATA_W-1:0]     odelta_q;
	logic [DATA_W-1:0]     num_q;
	logic [TIME_DIV_W-1:0] rem33_q;
	logic [DATA_W-1:0]     mean_q;
	logic [DATA_W-1:0]     x_q;
	logic                  sge_q;
	logic                  lge_q;
	logic [DATA_W-1:0]     sd_q;
	logic [DATA_W-1:0]     ld_q;
	logic                  upd_q;
	result_t               result_q;

	logic [TIME_DIV_W-1:0] div33_rem;
	logic [DIV33_BITS-1:0] div33_quo;
	logic [TIME_DIV_W:0]   div33_t;
	logic [TIME_DIV_W:0]   div33_d;

	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] short_sh;
	logic [DATA_W-1:0] long_sh;

	function automatic logic [DATA_W-1:0] ewma_next(
		input logic [DATA_W-1:0] acc,
		input logic              ge,
		input logic [DATA_W-1:0] d,
		input logic [WLOG_W-1:0] k
	);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] inc;
		logic              rnd;
		mask = (DATA_W'(1) << k) - DATA_W'(1);
		inc  = d >> k;
		rnd  = |(d & mask);
		if (ge)
			return acc + inc;
		return acc - inc - DATA_W'(rnd);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= THRESH_RESET;
			short_wlog_q <= SHORT_RESET;
			long_wlog_q  <= LONG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_THRESHOLD:    thresh_q     <= cfg_data[THRESH_W-1:0];
				REG_SHORT_WEIGHT: short_wlog_q <= cfg_data[WLOG_W-1:0];
				REG_LONG_WEIGHT:  long_wlog_q  <= cfg_data[WLOG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ticks_q <= '0;
			last_occ_q   <= '0;
			short_acc_q  <= '0;
			long_acc_q   <= '0;
			upd_q        <= 1'b0;
		end else begin
			if (cmd.load_sample) begin
				last_ticks_q <= sample.tick_sample;
				last_occ_q   <= sample.occupancy_total;
				upd_q        <= 1'b0;
			end
			if (cmd.ewma_apply) begin
				short_acc_q <= ewma_next(short_acc_q, sge_q, sd_q, short_wlog_q);
				long_acc_q  <= ewma_next(long_acc_q, lge_q, ld_q, long_wlog_q);
				upd_q       <= 1'b1;
			end
		end
	end

	always_comb begin
		div33_rem = rem33_q;
		div33_quo = '0;
		div33_t   = '0;
		div33_d   = '0;
		for (int i = 0; i < DIV33_BITS; i++) begin
			div33_t = {div33_rem, num_q[DATA_W-1-i]};
			div33_d = div33_t - TIME_DIV;
			if (div33_t >= TIME_DIV) begin
				div33_rem                = div33_d[TIME_DIV_W-1:0];
				div33_quo[DIV33_BITS-1-i] = 1'b1;
			end else begin
				div33_rem = div33_t[TIME_DIV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			tdelta_q <= sample.tick_sample - last_ticks_q;
			odelta_q <= sample.occupancy_total - last_occ_q;
			mean_q   <= '0;
		end
		if (cmd.scale) begin
			num_q   <= tdelta_q * TIME_MUL;
			rem33_q <= '0;
		end else if (cmd.div33_step) begin
			num_q   <= {num_q[DATA_W-DIV33_BITS-1:0], div33_quo};
			rem33_q <= div33_rem;
		end
		if (cmd.mean_load)
			mean_q <= div_quo;
		if (cmd.x_load)
			x_q <= ((mean_q > X_CAP) ? X_CAP : mean_q) << FRAC_BITS;
		if (cmd.ewma_diff) begin
			sge_q <= x_q >= short_acc_q;
			lge_q <= x_q >= long_acc_q;
			sd_q  <= (x_q >= short_acc_q) ? x_q - short_acc_q : short_acc_q - x_q;
			ld_q  <= (x_q >= long_acc_q) ? x_q - long_acc_q : long_acc_q - x_q;
		end
		if (cmd.out_load) begin
			result_q.elapsed_ns       <= num_q;
			result_q.mean_occupancy   <= mean_q;
			result_q.short_average    <= short_sh[AVG_W-1:0];
			result_q.long_average     <= long_sh[AVG_W-1:0];
			result_q.averages_updated <= upd_q;
		end
	end

	assign short_sh = short_acc_q >> FRAC_BITS;
	assign long_sh  = long_acc_q >> FRAC_BITS;

	orewma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (odelta_q),
		.divisor  ({1'b0, num_q[DATA_W-1:1]}),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign status.half_zero    = (num_q[DATA_W-1:1] == '0);
	assign status.above_thresh = mean_q > {{(DATA_W - THRESH_W){1'b0}}, thresh_q};
	assign status.div_done     = div_done;

	assign result = result_q;

endmodule

@@ rtl/orewma_ctrl.sv @@
// ---------------------------------------------------------------------------
// orewma_ctrl
// Sequencer for one sample at a time and owner of the result valid flag.
// ---------------------------------------------------------------------------
module orewma_ctrl
	import orewma_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	output logic    result_valid,
	input  logic    result_stall,
	output cmd_t    cmd,
	input  status_t status
);

	state_t                 state_q;
	state_t                 state_d;
	logic [DIV33_CNT_W-1:0] cnt_q;
	logic                   result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scale) begin
			cnt_q <= '0;
		end else if (cmd.div33_step) begin
			cnt_q <= cnt_q + DIV33_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (cmd.out_load)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DIV33;
			end
			ST_DIV33: begin
				cmd.div33_step = 1'b1;
				if (cnt_q == DIV33_CNT_W'(DIV33_STEPS - 1))
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.half_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.mean_load = 1'b1;
					state_d       = ST_THRESH;
				end
			end
			ST_THRESH: begin
				if (status.above_thresh) begin
					cmd.x_load = 1'b1;
					state_d    = ST_EWMA_DIFF;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EWMA_DIFF: begin
				cmd.ewma_diff = 1'b1;
				state_d       = ST_EWMA_APPLY;
			end
			ST_EWMA_APPLY: begin
				cmd.ewma_apply = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid_q || !result_stall))
		else $error("result overwritten before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> (state_q == ST_SCALE))
		else $error("sample transfer did not start processing");

endmodule

@@ rtl/occupancy_rate_ewma_tracker.sv @@
// ---------------------------------------------------------------------------
// occupancy_rate_ewma_tracker
// Mean queue occupancy from cumulative counter samples, with short- and
// long-term exponential averages.
// ---------------------------------------------------------------------------
// One sample is handled at a time. The deltas are formed when the sample is
// transferred; then ticks are scaled by ten, divided by 33 (eight quotient
// bits a cycle), and the serial restoring divider forms the mean, followed
// by the threshold check, the averaging (only above the threshold) and the
// result load. A sample whose halved time is zero skips the divider, the
// threshold check and the averaging. The next sample is taken as soon as
// the result sits in the output register, even if that result has not yet
// been transferred. Configuration writes are always taken and must be made
// only while the block is idle.
module occupancy_rate_ewma_tracker
	import orewma_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	orewma_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	orewma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.result    (result),
		.cfg_write (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
